// ----- src/srri_pkg.sv -----
`default_nettype none

package srri_pkg;

    localparam int unsigned MAX_RANGES_DEF = 16;
    localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd30000;

    typedef enum logic [1:0] {
        K_OPEN  = 2'd0,
        K_RANGE = 2'd1,
        K_STEP  = 2'd2,
        K_SENT  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ISSUE    = 3'd1,
        ST_REJECTED = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_COMPLETE = 3'd4,
        ST_FULL     = 3'd5,
        ST_INACTIVE = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0]  sender;
        logic [15:0] seq_from;
        logic [15:0] cursor;
        logic        exhausted;
    } t_range;

    typedef struct packed {
        logic    latch;
        logic    open;
        logic    refresh;
        logic    append;
        logic    clear;
        logic    scan_init;
        logic    advance;
        logic    issue;
        logic    finish;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  active;
        logic  peer_match;
        logic  timeout;
        logic  full;
        logic  cnt_zero;
        logic  live;
        logic  last_probe;
    } t_stat;

endpackage

`default_nettype wire

// ----- src/srri_ram.sv -----
`default_nettype none

module srri_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/srri_ctrl.sv -----
`default_nettype none

module srri_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire srri_pkg::t_stat i_stat,
    output srri_pkg::t_cmd     o_cmd,
    output logic               o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CHECK
    } t_state;

    t_state r_state;
    t_state n_state;
    srri_pkg::t_cmd cmd;

    always_comb begin
        cmd        = '0;
        cmd.status = srri_pkg::ST_OK;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state    = S_IDLE;
                cmd.finish = 1'b1;
                case (i_stat.kind)
                    srri_pkg::K_OPEN: begin
                        if (!i_stat.active) begin
                            cmd.open = 1'b1;
                        end else if (!i_stat.peer_match) begin
                            cmd.status = srri_pkg::ST_REJECTED;
                        end else begin
                            cmd.refresh = 1'b1;
                        end
                    end
                    srri_pkg::K_RANGE: begin
                        if (!i_stat.active) begin
                            cmd.status = srri_pkg::ST_INACTIVE;
                        end else if (!i_stat.peer_match) begin
                            cmd.status = srri_pkg::ST_REJECTED;
                        end else if (i_stat.full) begin
                            cmd.status = srri_pkg::ST_FULL;
                        end else begin
                            cmd.append = 1'b1;
                        end
                    end
                    srri_pkg::K_STEP: begin
                        if (!i_stat.active) begin
                            cmd.status = srri_pkg::ST_INACTIVE;
                        end else if (i_stat.timeout) begin
                            cmd.clear  = 1'b1;
                            cmd.status = srri_pkg::ST_TIMEOUT;
                        end else if (i_stat.cnt_zero) begin
                            cmd.clear  = 1'b1;
                            cmd.status = srri_pkg::ST_COMPLETE;
                        end else begin
                            cmd.finish    = 1'b0;
                            cmd.scan_init = 1'b1;
                            n_state       = S_READ;
                        end
                    end
                    srri_pkg::K_SENT: begin
                        if (!i_stat.active) begin
                            cmd.status = srri_pkg::ST_INACTIVE;
                        end else begin
                            cmd.refresh = 1'b1;
                        end
                    end
                    default: begin
                        cmd.status = srri_pkg::ST_INACTIVE;
                    end
                endcase
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                cmd.advance = 1'b1;
                if (i_stat.live) begin
                    cmd.issue  = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.status = srri_pkg::ST_ISSUE;
                    n_state    = S_IDLE;
                end else if (i_stat.last_probe) begin
                    cmd.clear  = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.status = srri_pkg::ST_COMPLETE;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- src/srri_dp.sv -----
`default_nettype none

module srri_dp #(
    parameter int unsigned MAX_RANGES = srri_pkg::MAX_RANGES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire srri_pkg::t_cmd i_cmd,
    output srri_pkg::t_stat     o_stat,
    input  wire logic           i_cfg_we,
    input  wire logic [31:0]    i_cfg_wdata,
    input  wire logic [1:0]     i_kind,
    input  wire logic [7:0]     i_peer_id,
    input  wire logic [7:0]     i_range_sender,
    input  wire logic [15:0]    i_range_from,
    input  wire logic [15:0]    i_range_to,
    input  wire logic           i_first_range,
    input  wire logic [31:0]    i_now_ms,
    output logic                o_done,
    output logic [2:0]          o_status,
    output logic [7:0]          o_issue_sender,
    output logic [15:0]         o_issue_seq,
    output logic                o_session_active
);

    localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
    localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int unsigned ENT_W = $bits(srri_pkg::t_range);

    // latched word
    srri_pkg::t_kind r_kind;
    logic [7:0]      r_peer;
    logic [7:0]      r_sender;
    logic [15:0]     r_from;
    logic [15:0]     r_to;
    logic            r_first;
    logic [31:0]     r_now;

    // session state
    logic             r_active;
    logic [7:0]       r_sess_peer;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_rr;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_tried;
    logic [31:0]      r_last;
    logic [31:0]      r_timeout;

    // result word
    logic                r_done;
    srri_pkg::t_status   r_status;
    logic [7:0]          r_isender;
    logic [15:0]         r_iseq;
    logic                r_out_act;

    srri_pkg::t_range rd_ent;
    srri_pkg::t_range wb_ent;
    srri_pkg::t_range new_ent;
    logic [ENT_W-1:0] ram_rdata;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_we;

    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W-1:0] tried_p1;
    logic [IDX_W-1:0] n_idx;
    logic [7:0]       rr_p1;
    logic [31:0]      age;
    logic             n_active;

    assign rd_ent = srri_pkg::t_range'(ram_rdata);

    always_comb begin
        cnt_eff  = r_first ? '0 : r_count;
        age      = r_now - r_last;
        rr_p1    = r_rr + 8'd1;
        idx_p1   = CNT_W'(r_idx) + CNT_W'(1);
        tried_p1 = r_tried + CNT_W'(1);
        if (rr_p1 == 8'd0 || idx_p1 == r_count) begin
            n_idx = '0;
        end else begin
            n_idx = idx_p1[IDX_W-1:0];
        end

        wb_ent = rd_ent;
        if (rd_ent.cursor == 16'd0) begin
            wb_ent.exhausted = 1'b1;
        end else begin
            wb_ent.cursor = rd_ent.cursor - 16'd1;
        end

        new_ent.sender    = r_sender;
        new_ent.seq_from  = r_from;
        new_ent.cursor    = r_to;
        new_ent.exhausted = 1'b0;

        ram_we    = i_cmd.append | i_cmd.issue;
        ram_waddr = i_cmd.append ? cnt_eff[IDX_W-1:0] : r_idx;
        ram_wdata = i_cmd.append ? ENT_W'(new_ent) : ENT_W'(wb_ent);

        if (i_cmd.clear) begin
            n_active = 1'b0;
        end else if (i_cmd.open) begin
            n_active = 1'b1;
        end else begin
            n_active = r_active;
        end

        o_stat.kind       = r_kind;
        o_stat.active     = r_active;
        o_stat.peer_match = (r_peer == r_sess_peer);
        o_stat.timeout    = (age > r_timeout);
        o_stat.full       = (cnt_eff >= CNT_W'(MAX_RANGES));
        o_stat.cnt_zero   = (r_count == '0);
        o_stat.live       = !rd_ent.exhausted && (rd_ent.cursor >= rd_ent.seq_from);
        o_stat.last_probe = (tried_p1 == r_count);
    end

    srri_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RANGES),
        .ADDR_W(IDX_W)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= srri_pkg::t_kind'(i_kind);
            r_peer   <= i_peer_id;
            r_sender <= i_range_sender;
            r_from   <= i_range_from;
            r_to     <= i_range_to;
            r_first  <= i_first_range;
            r_now    <= i_now_ms;
        end
        if (i_cmd.finish) begin
            r_status  <= i_cmd.status;
            r_out_act <= n_active;
            if (i_cmd.issue) begin
                r_isender <= rd_ent.sender;
                r_iseq    <= rd_ent.cursor;
            end else begin
                r_isender <= 8'd0;
                r_iseq    <= 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_sess_peer <= 8'd0;
            r_count     <= '0;
            r_rr        <= 8'd0;
            r_idx       <= '0;
            r_tried     <= '0;
            r_last      <= 32'd0;
            r_timeout   <= srri_pkg::IDLE_TIMEOUT_RST;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.scan_init) begin
                r_tried <= '0;
            end
            if (i_cmd.advance) begin
                r_rr    <= rr_p1;
                r_idx   <= n_idx;
                r_tried <= tried_p1;
            end
            if (i_cmd.refresh) begin
                r_last <= r_now;
            end
            if (i_cmd.append) begin
                r_count <= cnt_eff + CNT_W'(1);
                r_rr    <= 8'd0;
                r_idx   <= '0;
                r_last  <= r_now;
            end
            if (i_cmd.open) begin
                r_active    <= 1'b1;
                r_sess_peer <= r_peer;
                r_count     <= '0;
                r_rr        <= 8'd0;
                r_idx       <= '0;
                r_last      <= r_now;
            end
            if (i_cmd.clear) begin
                r_active    <= 1'b0;
                r_sess_peer <= 8'd0;
                r_count     <= '0;
                r_rr        <= 8'd0;
                r_idx       <= '0;
                r_last      <= 32'd0;
            end
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_issue_sender   = r_isender;
    assign o_issue_seq      = r_iseq;
    assign o_session_active = r_out_act;

endmodule

`default_nettype wire

// ----- src/sync_range_round_robin_issuer_top.sv -----
`default_nettype none

// Sync range issuer. A word is taken when i_start is high and o_busy is low;
// its one result appears on o_status, o_issue_sender, o_issue_seq and
// o_session_active for a single cycle marked by o_done. Open, add range and
// sent words, and a step that finds no session, times out or finds an empty
// table, are decided in S_EXEC. A step probes the range table one entry at a
// time through a single registered-read table memory, through S_READ and
// S_CHECK per entry, holding o_busy until it issues a live range or has
// probed every stored range. The receiver cannot stall: each result must be
// taken in its o_done cycle, and a new word may be started in that same
// cycle. The user must write the timeout register with i_cfg_we only while
// no word is in flight; the block itself does not enforce this.
module sync_range_round_robin_issuer_top #(
    parameter int unsigned MAX_RANGES = srri_pkg::MAX_RANGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_peer_id,
    input  wire logic [7:0]  i_range_sender,
    input  wire logic [15:0] i_range_from,
    input  wire logic [15:0] i_range_to,
    input  wire logic        i_first_range,
    input  wire logic [31:0] i_now_ms,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [7:0]       o_issue_sender,
    output logic [15:0]      o_issue_seq,
    output logic             o_session_active
);

    srri_pkg::t_cmd  cmd;
    srri_pkg::t_stat stat;

    srri_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (o_busy)
    );

    srri_dp #(
        .MAX_RANGES(MAX_RANGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_kind          (i_kind),
        .i_peer_id       (i_peer_id),
        .i_range_sender  (i_range_sender),
        .i_range_from    (i_range_from),
        .i_range_to      (i_range_to),
        .i_first_range   (i_first_range),
        .i_now_ms        (i_now_ms),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_issue_sender  (o_issue_sender),
        .o_issue_seq     (o_issue_seq),
        .o_session_active(o_session_active)
    );

endmodule

`default_nettype wire
